// ===== design/itap_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package itap_pkg;

  // Stream payload layout
  localparam int VALUE_W     = 64;
  localparam int FUNC_W      = 3;
  localparam int WIDTH_W     = 6;
  localparam int PREC_W      = 7;
  localparam int CH_W        = 8;
  localparam int IN_TDATA_W  = 88;
  localparam int IN_TUSER_W  = 4;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_MAX_FIELD  = 62;
  localparam int DEF_VALUE_BITS = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_SDEC = 3'd0,
    FN_UDEC = 3'd1,
    FN_HEXL = 3'd2,
    FN_HEXU = 3'd3,
    FN_PTR  = 3'd4
  } itap_func_e;

  localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [CH_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CH_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_X       = 8'h78;
  localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
  localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;

  // Control shared by every cell of the BCD row
  typedef struct packed {
    logic clear;
    logic shift;
  } itap_row_ctrl_t;

endpackage

`default_nettype wire

// ===== design/integer_to_padded_ascii.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Signals                        Contents
// s_axis    in   tvalid tready tdata tuser      one conversion request
// m_axis    out  tvalid tready tdata tlast      one character, tlast on the final one
//
// One request at a time. Decimal: BCD conversion in the cell row (one bit
// shifted per cycle), a sizing step, then one character per cycle while the
// output is not stalled. Hex and pointer skip the row and go straight to
// sizing. Undefined function codes are taken and dropped.
// Reset is asynchronous, active low. A stalled output holds the generator.
module integer_to_padded_ascii #(
  parameter int MAX_FIELD  = itap_pkg::DEF_MAX_FIELD,
  parameter int VALUE_BITS = itap_pkg::DEF_VALUE_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // value[63:0], plus_sign[64], space_sign[65], zero_pad[66], flag_prefix[67],
  // field_width[73:68], min_digits[80:74], zero fill above
  input  logic [itap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // func[2:0], wide[3]
  input  logic [itap_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // ch[7:0]
  output logic [itap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast
);

  import itap_pkg::*;

  localparam int NDIG  = (VALUE_BITS * 301) / 1000 + 1;
  localparam int NHEX  = (VALUE_BITS + 3) / 4;
  localparam int HEX_W = NHEX * 4;
  localparam int CNT_W = $clog2(MAX_FIELD + 1);
  localparam int ND_W  = $clog2(NDIG + 1);
  localparam int DG_W  = $clog2(NDIG);
  localparam int BC_W  = $clog2(VALUE_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CONV,
    S_SIZE,
    S_EMIT
  } state_e;

  state_e                  state_q;
  itap_func_e              func_q;
  logic                    neg_q, fplus_q, fspace_q, fzero_q, fprefix_q, pnone_q;
  logic [CNT_W-1:0]        width_q, precc_q;
  logic [VALUE_BITS-1:0]   sh_q;
  logic [BC_W-1:0]         bcnt_q;
  logic [CNT_W-1:0]        sp_cnt_q, zr_cnt_q;
  logic                    sign_pend_q, pfx0_pend_q, pfxx_pend_q;
  logic [CH_W-1:0]         sign_ch_q;
  logic [DG_W-1:0]         dg_idx_q;
  logic                    m_tvalid_q, m_last_q;
  logic [CH_W-1:0]         m_ch_q;

  // Request unpacking
  logic [VALUE_W-1:0]      value_in;
  itap_func_e              func_in;
  logic                    wide_in;
  logic [WIDTH_W-1:0]      width_in;
  logic [PREC_W-1:0]       prec_in;
  logic                    in_fire, is_dec_in, is_hex_in, use_wide;
  logic [VALUE_BITS-1:0]   mask, vm, val_ld;
  logic                    sbit, neg_in;
  logic [CNT_W-1:0]        width_sat, precc_in;

  assign value_in = s_axis_tdata[63:0];
  assign width_in = s_axis_tdata[73:68];
  assign prec_in  = s_axis_tdata[80:74];
  assign func_in  = itap_func_e'(s_axis_tuser[2:0]);
  assign wide_in  = s_axis_tuser[3];

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_dec_in     = (func_in == FN_SDEC) || (func_in == FN_UDEC);
  assign is_hex_in     = (func_in == FN_HEXL) || (func_in == FN_HEXU) || (func_in == FN_PTR);
  assign use_wide      = wide_in || (func_in == FN_PTR);
  assign mask          = use_wide ? {VALUE_BITS{1'b1}} : VALUE_BITS'(32'hffff_ffff);
  assign vm            = value_in[VALUE_BITS-1:0] & mask;
  assign sbit          = use_wide ? vm[VALUE_BITS-1] : vm[31];
  assign neg_in        = (func_in == FN_SDEC) && sbit;
  assign val_ld        = neg_in ? ((~vm + VALUE_BITS'(1)) & mask) : vm;

  assign width_sat = (width_in > WIDTH_W'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(width_in);
  assign precc_in  = prec_in[PREC_W-1] ? '0 :
                     (prec_in[5:0] > 6'(MAX_FIELD)) ? CNT_W'(MAX_FIELD) : CNT_W'(prec_in[5:0]);

  // BCD cell row
  itap_row_ctrl_t          row_ctrl;
  logic [NDIG*4-1:0]       bcd_flat;
  logic                    row_ovf;

  assign row_ctrl.clear = in_fire;
  assign row_ctrl.shift = (state_q == S_CONV);

  itap_bcd_row #(
    .NDIG (NDIG)
  ) u_row (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (row_ctrl),
    .bit_i    (sh_q[VALUE_BITS-1]),
    .digits_o (bcd_flat),
    .ovf_o    (row_ovf)
  );

  // Digit source: BCD row for decimal, nibbles of the held value for hex
  logic                    is_dec;
  logic [HEX_W-1:0]        hexv;
  logic [3:0]              src [NDIG];
  logic [ND_W-1:0]         nd;

  assign is_dec = (func_q == FN_SDEC) || (func_q == FN_UDEC);
  assign hexv   = HEX_W'(sh_q);

  for (genvar k = 0; k < NDIG; k++) begin : g_src
    if (k < NHEX) begin : g_both
      assign src[k] = is_dec ? bcd_flat[k*4 +: 4] : hexv[k*4 +: 4];
    end else begin : g_dec
      assign src[k] = is_dec ? bcd_flat[k*4 +: 4] : 4'd0;
    end
  end

  always_comb begin
    nd = ND_W'(1);
    for (int k = 0; k < NDIG; k++) begin
      if (src[k] != 4'd0) begin
        nd = ND_W'(k + 1);
      end
    end
  end

  // Padding split
  function automatic logic signed [7:0] clamp0(input logic signed [7:0] a);
    return (a < 0) ? 8'sd0 : a;
  endfunction

  logic                    has_sign, has_pfx;
  logic [CH_W-1:0]         sign_ch;
  logic signed [7:0]       nd_s, w_s, p_s, len_s, mw_s, pad_s, sp_s;

  assign has_sign = is_dec && (neg_q || fplus_q || fspace_q);
  assign has_pfx  = !is_dec && (fprefix_q || (func_q == FN_PTR));
  assign sign_ch  = neg_q ? CH_MINUS : (fplus_q ? CH_PLUS : CH_SPACE);

  always_comb begin
    nd_s  = $signed(8'(nd));
    w_s   = $signed(8'(width_q));
    p_s   = $signed(8'(precc_q));
    len_s = nd_s + $signed(8'(has_sign));
    mw_s  = (p_s > w_s) ? p_s : w_s;
    if (is_dec) begin
      pad_s = clamp0(w_s - len_s);
      sp_s  = clamp0(pad_s - clamp0(p_s - len_s));
      if (fzero_q && pnone_q) begin
        sp_s = 8'sd0;
      end
    end else begin
      pad_s = clamp0(mw_s - nd_s);
      if (has_pfx) begin
        pad_s = clamp0(pad_s - 8'sd2);
      end
      if (!pnone_q) begin
        sp_s = clamp0(pad_s - clamp0(p_s - nd_s));
      end else begin
        sp_s = fzero_q ? 8'sd0 : pad_s;
      end
    end
  end

  // Character generator
  logic                    emit_go, emit_last, emit_digit;
  logic [3:0]              dval;
  logic [CH_W-1:0]         dig_ch, emit_ch;

  assign emit_go = (state_q == S_EMIT) && (!m_tvalid_q || m_axis_tready);
  assign dval    = src[dg_idx_q];
  assign dig_ch  = (is_dec || dval < 4'd10) ? (CH_ZERO + CH_W'(dval)) :
                   (((func_q == FN_HEXU) ? CH_UPPER_A : CH_LOWER_A) + CH_W'(dval) - 8'd10);

  always_comb begin
    emit_digit = 1'b0;
    priority if (sp_cnt_q != '0) begin
      emit_ch = CH_SPACE;
    end else if (sign_pend_q) begin
      emit_ch = sign_ch_q;
    end else if (pfx0_pend_q) begin
      emit_ch = CH_ZERO;
    end else if (pfxx_pend_q) begin
      emit_ch = CH_X;
    end else if (zr_cnt_q != '0) begin
      emit_ch = CH_ZERO;
    end else begin
      emit_ch    = dig_ch;
      emit_digit = 1'b1;
    end
  end

  assign emit_last = emit_digit && (dg_idx_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FN_SDEC;
      neg_q       <= 1'b0;
      fplus_q     <= 1'b0;
      fspace_q    <= 1'b0;
      fzero_q     <= 1'b0;
      fprefix_q   <= 1'b0;
      pnone_q     <= 1'b0;
      width_q     <= '0;
      precc_q     <= '0;
      sh_q        <= '0;
      bcnt_q      <= '0;
      sp_cnt_q    <= '0;
      zr_cnt_q    <= '0;
      sign_pend_q <= 1'b0;
      pfx0_pend_q <= 1'b0;
      pfxx_pend_q <= 1'b0;
      sign_ch_q   <= '0;
      dg_idx_q    <= '0;
      m_tvalid_q  <= 1'b0;
      m_last_q    <= 1'b0;
      m_ch_q      <= '0;
    end else begin
      if (m_tvalid_q && m_axis_tready && !emit_go) begin
        m_tvalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            func_q    <= func_in;
            neg_q     <= neg_in;
            fplus_q   <= s_axis_tdata[64];
            fspace_q  <= s_axis_tdata[65];
            fzero_q   <= s_axis_tdata[66];
            fprefix_q <= s_axis_tdata[67];
            pnone_q   <= (prec_in == {PREC_W{1'b1}});
            width_q   <= width_sat;
            precc_q   <= precc_in;
            sh_q      <= val_ld;
            bcnt_q    <= BC_W'(VALUE_BITS - 1);
            // undefined codes: take the transfer and drop it
            if (is_dec_in) begin
              state_q <= S_CONV;
            end else if (is_hex_in) begin
              state_q <= S_SIZE;
            end
          end
        end
        S_CONV: begin
          sh_q <= sh_q << 1;
          if (bcnt_q == '0) begin
            state_q <= S_SIZE;
          end else begin
            bcnt_q <= bcnt_q - BC_W'(1);
          end
        end
        S_SIZE: begin
          sp_cnt_q    <= CNT_W'(sp_s);
          zr_cnt_q    <= CNT_W'(pad_s - sp_s);
          sign_pend_q <= has_sign;
          sign_ch_q   <= sign_ch;
          pfx0_pend_q <= has_pfx;
          pfxx_pend_q <= has_pfx;
          dg_idx_q    <= DG_W'(nd - ND_W'(1));
          state_q     <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_go) begin
            m_tvalid_q <= 1'b1;
            m_ch_q     <= emit_ch;
            m_last_q   <= emit_last;
            priority if (sp_cnt_q != '0) begin
              sp_cnt_q <= sp_cnt_q - CNT_W'(1);
            end else if (sign_pend_q) begin
              sign_pend_q <= 1'b0;
            end else if (pfx0_pend_q) begin
              pfx0_pend_q <= 1'b0;
            end else if (pfxx_pend_q) begin
              pfxx_pend_q <= 1'b0;
            end else if (zr_cnt_q != '0) begin
              zr_cnt_q <= zr_cnt_q - CNT_W'(1);
            end else if (dg_idx_q != '0) begin
              dg_idx_q <= dg_idx_q - DG_W'(1);
            end else begin
              state_q <= S_IDLE;
            end
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = m_ch_q;
  assign m_axis_tlast  = m_last_q;

  // The row must hold every decimal digit of the widest value
  a_row_no_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> !row_ovf)
    else $error("BCD row overflow during conversion");

  a_conv_dec_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CONV) |-> ((func_q == FN_SDEC) || (func_q == FN_UDEC)))
    else $error("conversion run for a non-decimal request");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_go && emit_last) |=> (state_q == S_IDLE))
    else $error("generator did not return to idle after the final character");

  a_idle_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ((sp_cnt_q == '0) && (zr_cnt_q == '0) && !sign_pend_q))
    else $error("padding left over when idle");

endmodule

`default_nettype wire

// ===== design/itap_bcd_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itap_bcd_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  itap_pkg::itap_row_ctrl_t ctrl_i,
  input  logic                   carry_i,
  output logic                   carry_o,
  output logic [3:0]             digit_o
);

  logic [3:0] digit_q;
  logic [3:0] adj;

  // add three before the shift so the doubled digit carries at ten
  assign adj     = (digit_q >= 4'd5) ? (digit_q + 4'd3) : digit_q;
  assign carry_o = adj[3];
  assign digit_o = digit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= 4'd0;
    end else if (ctrl_i.clear) begin
      digit_q <= 4'd0;
    end else if (ctrl_i.shift) begin
      digit_q <= {adj[2:0], carry_i};
    end
  end

endmodule

`default_nettype wire

// ===== design/itap_bcd_row.sv =====
`timescale 1ns / 1ps
`default_nettype none

module itap_bcd_row #(
  parameter int NDIG = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  itap_pkg::itap_row_ctrl_t ctrl_i,
  input  logic                     bit_i,
  output logic [NDIG*4-1:0]        digits_o,
  output logic                     ovf_o
);

  logic [NDIG:0] carry;

  assign carry[0] = bit_i;
  assign ovf_o    = carry[NDIG];

  for (genvar k = 0; k < NDIG; k++) begin : g_cell
    itap_bcd_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl_i),
      .carry_i (carry[k]),
      .carry_o (carry[k+1]),
      .digit_o (digits_o[k*4 +: 4])
    );
  end

endmodule

`default_nettype wire

// ===== sim/tb_integer_to_padded_ascii.sv =====
`timescale 1ns / 1ps

module tb_integer_to_padded_ascii;
  import itap_pkg::*;

  localparam logic [FUNC_W-1:0] FN_UNDEF_5 = 3'd5;
  localparam logic [FUNC_W-1:0] FN_UNDEF_7 = 3'd7;
  localparam int DIR_N       = 25;
  localparam int RAND_ITEMS  = 115;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [FUNC_W-1:0]  func;
    logic               wide;
    logic               plus;
    logic               space;
    logic               zero;
    logic               prefix;
    logic [WIDTH_W-1:0] width;
    logic [PREC_W-1:0]  prec;
  } conv_req_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } char_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  char_t     text_q[$];
  char_t     want;
  int        errors_seen = 0;
  int        chars_checked = 0;
  int        reqs_sent = 0;
  int        undef_sent = 0;
  int        burst_left = 0;
  int        rx_mode = 0;
  int        rx_left = 0;
  int        rx_phase = 0;
  conv_req_t dir_req[DIR_N];
  string     dir_text[DIR_N];

  integer_to_padded_ascii u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int imax(int a, int b);
    return a > b ? a : b;
  endfunction

  function automatic string fill(string c, int n);
    string s = "";
    for (int i = 0; i < n; i++) s = {s, c};
    return s;
  endfunction

  function automatic conv_req_t mk(logic [63:0] value, logic [FUNC_W-1:0] func, bit wide,
                                   bit plus, bit space, bit zero, bit prefix,
                                   int width, int prec);
    conv_req_t r;
    r.value  = value;
    r.func   = func;
    r.wide   = wide;
    r.plus   = plus;
    r.space  = space;
    r.zero   = zero;
    r.prefix = prefix;
    r.width  = width[WIDTH_W-1:0];
    r.prec   = prec[PREC_W-1:0];
    return r;
  endfunction

  // Expected text of one conversion; empty for undefined function codes
  function automatic string render_text(conv_req_t r);
    int          w, p, len, pad, sp;
    logic [63:0] v;
    bit          neg, pfx;
    string       digs, sign, lead;
    w = imax(0, r.width > DEF_MAX_FIELD ? DEF_MAX_FIELD : int'(r.width));
    p = int'($signed(r.prec));
    if (p > DEF_MAX_FIELD) p = DEF_MAX_FIELD;
    case (r.func)
      FN_SDEC, FN_UDEC: begin
        v   = r.wide ? r.value : {32'h0, r.value[31:0]};
        neg = (r.func == FN_SDEC) && (r.wide ? v[63] : v[31]);
        if (neg) begin
          if (r.wide) v = ~v + 64'd1;
          else v[31:0] = ~v[31:0] + 32'd1;
        end
        digs = $sformatf("%0d", v);
        sign = "";
        if (neg) sign = "-";
        else if (r.plus) sign = "+";
        else if (r.space) sign = " ";
        len  = digs.len() + sign.len();
        pad  = imax(w - len, 0);
        sp   = imax(pad - imax(imax(p, 0) - len, 0), 0);
        if (r.zero && p == -1) sp = 0;
        return {fill(" ", sp), sign, fill("0", pad - sp), digs};
      end
      FN_HEXL, FN_HEXU, FN_PTR: begin
        pfx  = r.prefix || r.func == FN_PTR;
        v    = (r.wide || r.func == FN_PTR) ? r.value : {32'h0, r.value[31:0]};
        digs = $sformatf("%0h", v);
        if (r.func == FN_HEXU) digs = digs.toupper();
        lead = "";
        if (pfx) lead = "0x";
        pad = imax(imax(w, p) - digs.len(), 0);
        if (pfx) pad = imax(pad - 2, 0);
        sp = pad;
        if (p != -1) sp = imax(pad - imax(p - digs.len(), 0), 0);
        else if (r.zero) sp = 0;
        return {fill(" ", sp), lead, fill("0", pad - sp), digs};
      end
      default: return "";
    endcase
  endfunction

  function automatic conv_req_t rand_req();
    conv_req_t r;
    int        k;
    r = '0;
    r.func = ($urandom_range(0, 99) < 8) ? FUNC_W'($urandom_range(5, 7))
                                         : FUNC_W'($urandom_range(0, 4));
    k = $urandom_range(0, 9);
    case (k)
      0:       r.value = 64'(3'($urandom_range(0, 7)));
      1:       r.value = '1;
      2:       r.value = {32'($urandom), 32'h8000_0000};
      3:       r.value = 64'h8000_0000_0000_0000;
      4:       r.value = {32'($urandom), 32'h7fff_ffff};
      5:       r.value = 64'($urandom_range(0, 99999));
      default: r.value = {32'($urandom), 32'($urandom)};
    endcase
    r.wide   = 1'($urandom_range(0, 1));
    r.plus   = $urandom_range(0, 3) == 0;
    r.space  = $urandom_range(0, 3) == 0;
    r.zero   = $urandom_range(0, 2) == 0;
    r.prefix = 1'($urandom_range(0, 1));
    // mostly modest widths, now and then the whole range
    r.width = ($urandom_range(0, 4) == 0) ? WIDTH_W'($urandom) : WIDTH_W'($urandom_range(0, 25));
    k = $urandom_range(0, 9);
    if (k < 4) r.prec = '1;
    else if (k < 8) r.prec = PREC_W'($urandom_range(0, 25));
    else r.prec = PREC_W'($urandom);
    return r;
  endfunction

  task automatic send_req(conv_req_t r, string text);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'h0, r.prec, r.width, r.prefix, r.zero, r.space, r.plus, r.value};
    s_axis_tuser  <= {r.wide, r.func};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    for (int i = 0; i < text.len(); i++) text_q.push_back({text[i], i == text.len() - 1});
    reqs_sent++;
    if (r.func > FN_PTR) undef_sent++;
    @(negedge clk_i);
    if (burst_left == 0) begin
      // end of burst: drop valid before the next request
      burst_left = ($urandom_range(0, 3) == 0) ? 30 : $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  // Receiver: switch between stall patterns every so often
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 120);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      0:       m_axis_tready <= 1'b1;
      1:       m_axis_tready <= 1'($urandom_range(0, 1));
      2:       m_axis_tready <= (rx_phase % 3) != 0;
      default: m_axis_tready <= $urandom_range(0, 3) == 0;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (text_q.size() == 0) begin
        $error("unexpected character: ch %h last %b", m_axis_tdata, m_axis_tlast);
        errors_seen++;
      end else begin
        want = text_q.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want.ch) begin
          $error("ch: expected %h, actual %h", want.ch, m_axis_tdata);
          errors_seen++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, actual %b", want.last, m_axis_tlast);
          errors_seen++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("[integer_to_padded_ascii] ERROR");
    $finish;
  end

  initial begin
    conv_req_t r;
    int        good;
    // "?" marks a row checked against the predictor
    dir_req = '{
      mk(64'h0,                  FN_SDEC,    0, 0, 0, 0, 0, 0, -1),
      mk(64'h8000_0000,          FN_SDEC,    0, 0, 0, 0, 0, 0, -1),
      mk(64'h8000_0000_0000_0000, FN_SDEC,   1, 0, 0, 0, 0, 0, -1),
      mk('1,                     FN_UDEC,    1, 0, 0, 0, 0, 0, -1),
      mk('1,                     FN_UDEC,    0, 0, 0, 0, 0, 0, -1),
      mk(64'h0,                  FN_HEXL,    0, 0, 0, 0, 0, 0, -1),
      mk(64'h1234_5678_dead_beef, FN_HEXU,   0, 0, 0, 0, 0, 0, -1),
      mk('1,                     FN_HEXL,    1, 0, 0, 0, 1, 0, -1),
      mk(64'h0,                  FN_PTR,     0, 0, 0, 0, 0, 0, -1),
      mk('1,                     FN_UNDEF_5, 1, 1, 1, 1, 1, 63, 63),
      mk(64'h2a,                 FN_UNDEF_7, 0, 0, 0, 0, 0, 10, 5),
      mk(64'd42,                 FN_SDEC,    0, 1, 0, 0, 0, 0, -1),
      mk(64'd42,                 FN_SDEC,    0, 0, 1, 0, 0, 0, -1),
      mk(64'd42,                 FN_SDEC,    0, 1, 1, 0, 0, 0, -1),
      mk(64'hffff_fffb,          FN_SDEC,    0, 0, 0, 0, 0, 5, -1),
      mk(64'd42,                 FN_SDEC,    0, 1, 0, 1, 0, 6, -1),
      mk(64'd7,                  FN_UDEC,    0, 0, 0, 0, 0, 63, -1),
      mk(64'hab,                 FN_HEXL,    0, 0, 0, 0, 0, 0, 63),
      mk(64'h1,                  FN_HEXL,    0, 0, 0, 1, 0, 8, -2),
      mk(64'hffff_fff9,          FN_SDEC,    0, 0, 0, 1, 0, 10, -64),
      mk(64'habc,                FN_HEXU,    0, 1, 1, 0, 1, 10, 6),
      mk(64'd12345,              FN_SDEC,    0, 0, 0, 0, 0, 5, 8),
      mk(64'hffff_ffff_0000_0001, FN_PTR,    0, 0, 0, 1, 0, 20, -1),
      mk('1,                     FN_UDEC,    1, 0, 1, 0, 0, 62, 62),
      mk(64'h5a5a_0000_ffff_ffff, FN_HEXL,   0, 0, 0, 1, 1, 12, -1)
    };
    dir_text = '{
      "0", "-2147483648", "-9223372036854775808", "18446744073709551615", "4294967295",
      "0", "DEADBEEF", "0xffffffffffffffff", "0x0", "", "",
      "+42", " 42", "+42", "   -5", "+00042",
      "?", "?", "?", "?", "?", "?", "?", "?", "?"
    };

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DIR_N; i++)
      send_req(dir_req[i], dir_text[i] == "?" ? render_text(dir_req[i]) : dir_text[i]);

    good = 0;
    while (good < RAND_ITEMS) begin
      r = rand_req();
      if (r.func <= FN_PTR) good++;
      send_req(r, render_text(r));
    end
    s_axis_tvalid <= 1'b0;

    wait (text_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d conversion requests (%0d directed, %0d with undefined codes)",
             reqs_sent, DIR_N, undef_sent);
    $display("Checked %0d output characters, %0d mismatches", chars_checked, errors_seen);
    if (errors_seen == 0 && text_q.size() == 0) begin
      $display("[integer_to_padded_ascii] OK");
    end else begin
      $display("[integer_to_padded_ascii] ERROR");
    end
    $finish;
  end

endmodule
